>>> src/dq_pkg.sv
// Shared constants and types for the double-ended queue.
// Depends on nothing; every other file in src depends on it.
package dq_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What one storage cell does at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_t;

endpackage

>>> src/dq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on dq_pkg for widths.
interface dq_req_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        req_type;
  logic signed [dq_pkg::VALUE_W-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink (input valid, req_type, push_value, output ready);
endinterface

interface dq_resp_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::VALUE_W-1:0] out_value;
  logic [1:0]                        status;
  logic [dq_pkg::CNT_W-1:0]          entry_count;

  modport source (output valid, out_value, status, entry_count, input ready);
  modport sink (input valid, out_value, status, entry_count, output ready);
endinterface

>>> src/dq_cell.sv
// One storage cell of the queue row: holds a value, loads a new one or
// takes its left or right neighbor's value. Depends on dq_pkg.
module dq_cell (
  input  logic                              clk,
  input  dq_pkg::cell_op_t                  op,
  input  logic signed [dq_pkg::VALUE_W-1:0] left_value,
  input  logic signed [dq_pkg::VALUE_W-1:0] right_value,
  input  logic signed [dq_pkg::VALUE_W-1:0] load_value,
  output logic signed [dq_pkg::VALUE_W-1:0] value
);
  import dq_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:       value <= load_value;
      CELL_FROM_LEFT:  value <= left_value;
      CELL_FROM_RIGHT: value <= right_value;
      default:         value <= value;
    endcase
  end

endmodule

>>> src/double_ended_queue.sv
// Double-ended queue built from a row of shifting cells; cell 0 is the front.
// The response is registered in the cycle after its request transfer.
// Throughput: one request per cycle while no response is held back; peeks and back pops move no cell.
// Reset (rst, synchronous) empties the queue and drops any pending response.
// Depends on dq_pkg, dq_if and dq_cell.
module double_ended_queue (
  input  logic clk,
  input  logic rst,
  dq_req_if.sink    req,
  dq_resp_if.source resp
);
  import dq_pkg::*;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     accept;
  logic                     full;
  logic                     empty;
  cell_op_t                 cell_op [DEPTH];
  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  logic signed [VALUE_W-1:0] back_value;
  logic signed [VALUE_W-1:0] result_value;
  status_t                  result_status;

  assign req.ready = !resp.valid || resp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  // The back entry is the cell just below the count.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_value[i] & {VALUE_W{count == CNT_W'(i + 1)}});
    end
  end

  always_comb begin
    count_next    = count;
    result_value  = '0;
    result_status = ST_OK;
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end
    case (req.req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          result_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
          end
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          result_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
          for (int i = 0; i < DEPTH; i++) begin
            if (count == CNT_W'(i)) cell_op[i] = CELL_LOAD;
          end
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          result_status = ST_EMPTY;
        end else begin
          result_value = cell_value[0];
          count_next   = count - CNT_W'(1);
          for (int i = 0; i < DEPTH - 1; i++) begin
            cell_op[i] = CELL_FROM_RIGHT;
          end
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          result_status = ST_EMPTY;
        end else begin
          result_value = back_value;
          count_next   = count - CNT_W'(1);
        end
      end
      REQ_PEEK_FRONT: begin
        if (empty) result_status = ST_EMPTY;
        else result_value = cell_value[0];
      end
      REQ_PEEK_BACK: begin
        if (empty) result_status = ST_EMPTY;
        else result_value = back_value;
      end
      default: begin
      end
    endcase
    // Nothing moves unless the request is actually transferred.
    if (!accept) begin
      count_next = count;
      for (int i = 0; i < DEPTH; i++) begin
        cell_op[i] = CELL_HOLD;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dq_cell u_cell (
      .clk         (clk),
      .op          (cell_op[g]),
      .left_value  ((g == 0) ? req.push_value : cell_value[(g == 0) ? 0 : g - 1]),
      .right_value ((g == DEPTH - 1) ? cell_value[g]
                                     : cell_value[(g == DEPTH - 1) ? g : g + 1]),
      .load_value  (req.push_value),
      .value       (cell_value[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      resp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        resp.valid <= 1'b1;
      end else if (resp.ready) begin
        resp.valid <= 1'b0;
      end
    end
    if (accept) begin
      resp.out_value   <= result_value;
      resp.status      <= result_status;
      resp.entry_count <= count_next;
    end
  end

endmodule
